>>> hw/rtl/key_matrix_scan_debounce_defines.svh
// assertion macros for the key matrix scanner
// no dependencies; included by the files that check their own logic
`ifndef KEY_MATRIX_SCAN_DEBOUNCE_DEFINES_SVH
`define KEY_MATRIX_SCAN_DEBOUNCE_DEFINES_SVH
`ifndef SYNTHESIS
`define KMSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KMSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KMSD_ASSERT(lbl, prop, msg)
`define KMSD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/kmsd_pkg.sv
// shared constants, types and the pin permutation of the key matrix scanner
// no dependencies
package kmsd_pkg;

  localparam int ROWS      = 8;
  localparam int COLS      = 16;
  localparam int PINS      = 8;
  localparam int COL_W     = 4;
  localparam int TIME_W    = 16;
  localparam int DEB_W     = 8;
  localparam int ROW_IDX_W = 3;
  localparam int IN_W      = 32;
  localparam int OUT_W     = 24;
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = DEB_W'(5);

  typedef logic [2:0] pin_row_t;
  localparam pin_row_t PIN_TO_ROW [PINS] = '{
    3'd5, 3'd0, 3'd3, 3'd2, 3'd4, 3'd1, 3'd6, 3'd7
  };

  typedef logic [PINS-1:0] sample_t;
  typedef logic [ROWS-1:0][COLS-1:0] rows_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic sample_t permute_pins(input sample_t pins);
    sample_t v;
    v = '0;
    for (int i = 0; i < PINS; i++) begin
      if (pins[i]) begin
        v[PIN_TO_ROW[i]] = 1'b1;
      end
    end
    return v;
  endfunction

endpackage

>>> hw/rtl/key_matrix_scan_debounce.sv
// top level of the key matrix scanner with global debounce
// depends on kmsd_pkg, kmsd_front, kmsd_queue and kmsd_back
//
// in_* takes one request per strobed column: index, raw sense pins, ms timestamp.
// Pins are mapped to logical rows and compared with the stored column sample.
// When the last column arrives unchanged with a change pending and more than
// cfg_wr_data ms (written through cfg_wr_en) since that change, all samples are
// transposed into eight row words and sent on out_*, row 0 first, tlast on row 7.
// A column request is taken while in_tready is high, which holds while the
// snapshot queue (two commits deep) has room. A commit goes through the queue, the
// stable row register and the output register, then one word per cycle while
// out_tready is high; out_tvalid drops between commits as the next one loads.
// A stalled receiver holds the current word; once the queue fills, in_tready drops.
// Reset clears all samples, the pending flag and change time, the queue, and
// sets the debounce time to 5 ms.
module key_matrix_scan_debounce (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [kmsd_pkg::DEB_W-1:0]   cfg_wr_data,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [kmsd_pkg::IN_W-1:0]    in_tdata,   // column, sense_pins, now_ms
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [kmsd_pkg::OUT_W-1:0]   out_tdata,  // row_index, row_bits
  output logic                         out_tlast
);
  import kmsd_pkg::*;

  qstat_t q_stat;
  logic   q_push;
  logic   q_pop;
  rows_t  q_wdata;
  rows_t  q_rdata;

  kmsd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  kmsd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  kmsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> hw/rtl/kmsd_front.sv
// front end: column requests, sample store, change tracking and commit decision
// depends on kmsd_pkg
module kmsd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [kmsd_pkg::DEB_W-1:0]   cfg_wr_data,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [kmsd_pkg::IN_W-1:0]    in_tdata,
  input  kmsd_pkg::qstat_t             q_stat,
  output logic                         q_push,
  output kmsd_pkg::rows_t              q_wdata
);
  import kmsd_pkg::*;

  logic [DEB_W-1:0]  debounce_r;
  sample_t           samples_r [COLS];
  logic              pending_r;
  logic [TIME_W-1:0] change_time_r;

  logic [COL_W-1:0]  col;
  sample_t           sample;
  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] elapsed;
  logic              accept;
  logic              col_ok;
  logic              changed;
  logic              commit;

  assign col    = in_tdata[COL_W-1:0];
  assign sample = permute_pins(in_tdata[COL_W +: PINS]);
  assign now    = in_tdata[COL_W+PINS +: TIME_W];

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign col_ok    = 32'(col) < COLS;
  assign changed   = col_ok && (samples_r[col[$clog2(COLS > 1 ? COLS : 2)-1:0]] != sample);
  assign elapsed   = now - change_time_r;
  assign commit    = col_ok && (32'(col) == COLS - 1) && !changed && pending_r &&
                     (elapsed > TIME_W'(debounce_r));
  assign q_push    = accept && commit;

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        q_wdata[r][c] = samples_r[c][r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= DEBOUNCE_RST;
      pending_r     <= 1'b0;
      change_time_r <= '0;
      for (int c = 0; c < COLS; c++) begin
        samples_r[c] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        debounce_r <= cfg_wr_data;
      end
      if (accept && changed) begin
        samples_r[col[$clog2(COLS > 1 ? COLS : 2)-1:0]] <= sample;
        pending_r     <= 1'b1;
        change_time_r <= now;
      end else if (q_push) begin
        pending_r <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/kmsd_queue.sv
// short queue of committed row snapshots between front and back end
// depends on kmsd_pkg
`include "key_matrix_scan_debounce_defines.svh"
module kmsd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  kmsd_pkg::rows_t  wdata,
  input  logic             pop,
  output kmsd_pkg::rows_t  rdata,
  output kmsd_pkg::qstat_t stat
);
  import kmsd_pkg::*;

  rows_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] cnt_r;
  logic            do_push;
  logic            do_pop;

  assign stat.full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + Q_CW'(do_push) - Q_CW'(do_pop);
    end
  end

  `KMSD_ASSERT(a_q_no_overflow, push |-> !stat.full, "commit pushed into full queue")
  `KMSD_ASSERT(a_q_no_underflow, pop |-> !stat.empty, "pop from empty queue")
  `KMSD_ASSERT(a_q_count_step, (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1),
    "queue count did not follow push")

endmodule

>>> hw/rtl/kmsd_back.sv
// back end: holds the stable row words and sends them one word at a time on out_*
// depends on kmsd_pkg
`include "key_matrix_scan_debounce_defines.svh"
module kmsd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kmsd_pkg::qstat_t          q_stat,
  input  kmsd_pkg::rows_t           q_rdata,
  output logic                      q_pop,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [kmsd_pkg::OUT_W-1:0] out_tdata,
  output logic                      out_tlast
);
  import kmsd_pkg::*;

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t                state_r;
  rows_t                 stable_rows_r;
  logic [ROW_IDX_W-1:0]  idx_r;
  logic                  out_valid_r;
  logic [ROW_IDX_W-1:0]  out_row_r;
  logic [COLS-1:0]       out_bits_r;
  logic                  out_last_r;
  logic                  load;
  logic                  at_last;

  assign load    = !out_valid_r || out_tready;
  assign at_last = (idx_r == ROW_IDX_W'(ROWS - 1));
  assign q_pop   = (state_r == ST_IDLE) && !q_stat.empty;

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_W'({out_bits_r, out_row_r});

  always_ff @(posedge clk) begin
    if (q_pop) begin
      stable_rows_r <= q_rdata;
    end
    if (load && state_r == ST_EMIT) begin
      out_row_r  <= idx_r;
      out_bits_r <= stable_rows_r[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (load) begin
            out_valid_r <= 1'b0;
          end
          if (q_pop) begin
            idx_r   <= '0;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load) begin
            out_valid_r <= 1'b1;
            out_last_r  <= at_last;
            idx_r       <= idx_r + 1'b1;
            if (at_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `KMSD_ASSERT_ALWAYS(a_back_reset_quiet, !rst_n |=> !out_valid_r,
    "row word valid right after reset")
  `KMSD_ASSERT(a_back_last_is_top_row, (out_valid_r && out_last_r) |->
    (out_row_r == ROW_IDX_W'(ROWS - 1)), "last flag on wrong row")
  `KMSD_ASSERT(a_back_hold_on_stall, (out_valid_r && !out_tready) |=>
    (out_valid_r && $stable(out_row_r) && $stable(out_bits_r)), "stalled row word moved")

endmodule

>>> verif/tb_key_matrix_scan_debounce.sv
// self-checking testbench for key_matrix_scan_debounce: column strobes in, committed row words out
// depends on kmsd_pkg and the key_matrix_scan_debounce rtl; holds its own scanner model,
// a queue-fed request driver, random stalls on both sides and a row word checker
module tb_key_matrix_scan_debounce;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ROWS = 8;
  localparam int NUM_COLS = 16;
  localparam int SETTLE_CYCLES = 12;
  localparam int unsigned PIN_ROW [8] = '{5, 0, 3, 2, 4, 1, 6, 7};

  typedef struct packed {
    logic [3:0]  column;
    logic [7:0]  pins;
    logic [15:0] now_ms;
  } strobe_t;

  typedef struct packed {
    logic [2:0]  row_index;
    logic [15:0] row_bits;
    logic        last_row;
  } row_word_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_wr_en = 1'b0;
  logic [kmsd_pkg::DEB_W-1:0]    cfg_wr_data = '0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [kmsd_pkg::IN_W-1:0]     in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [kmsd_pkg::OUT_W-1:0]    out_tdata;
  logic                          out_tlast;

  strobe_t   strobe_queue [$];
  row_word_t expected_rows [$];
  strobe_t   next_strobe;
  row_word_t seen_row;
  row_word_t want_row;

  logic [7:0]  column_image [NUM_COLS];
  logic        change_pending;
  logic [15:0] change_ms;
  logic [7:0]  debounce_ms_model;
  int          commit_count;
  int          mismatch_count;
  int          strobes_queued;
  logic        steady_run;
  logic [3:0]  gap_left;
  logic [3:0]  stall_left;

  logic [7:0]  raw_pins [NUM_COLS];
  logic [15:0] scan_ms;

  key_matrix_scan_debounce u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),   // column, sense_pins, now_ms
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),  // row_index, row_bits
    .out_tlast   (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic absorb_strobe(input logic [3:0] col, input logic [7:0] pins,
                               input logic [15:0] now_ms);
    logic [7:0]  mapped;
    logic [15:0] elapsed;
    row_word_t   w;
    mapped = '0;
    for (int i = 0; i < 8; i++) begin
      if (pins[i]) mapped[PIN_ROW[i]] = 1'b1;
    end
    if (column_image[col] != mapped) begin
      column_image[col] = mapped;
      change_pending = 1'b1;
      change_ms = now_ms;
    end
    if (col == NUM_COLS - 1) begin
      elapsed = now_ms - change_ms;
      if (change_pending && elapsed > {8'd0, debounce_ms_model}) begin
        change_pending = 1'b0;
        commit_count++;
        for (int r = 0; r < NUM_ROWS; r++) begin
          w.row_index = 3'(r);
          for (int c = 0; c < NUM_COLS; c++) w.row_bits[c] = column_image[c][r];
          w.last_row = (r == NUM_ROWS - 1);
          expected_rows.push_back(w);
        end
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (!steady_run && gap_left != 0) begin
        gap_left <= gap_left - 1'b1;
        in_tvalid <= 1'b0;
      end else if (!steady_run && $urandom_range(0, 7) == 0) begin
        gap_left <= 4'($urandom_range(0, 10));
        in_tvalid <= 1'b0;
      end else if (strobe_queue.size() != 0) begin
        next_strobe = strobe_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {4'b0, next_strobe.now_ms, next_strobe.pins, next_strobe.column};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      absorb_strobe(in_tdata[3:0], in_tdata[11:4], in_tdata[27:12]);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= '0;
    end else if (steady_run) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1'b1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= 4'($urandom_range(0, 10));
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // row word checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_row.row_index = out_tdata[2:0];
      seen_row.row_bits = out_tdata[18:3];
      seen_row.last_row = out_tlast;
      if (expected_rows.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected row word: expected none actual %h", $time, seen_row);
      end else begin
        want_row = expected_rows.pop_front();
        if (seen_row.row_index != want_row.row_index) begin
          mismatch_count++;
          $display("%0t row_index: expected %0d actual %0d", $time,
                   want_row.row_index, seen_row.row_index);
        end
        if (seen_row.row_bits != want_row.row_bits) begin
          mismatch_count++;
          $display("%0t row_bits: expected %h actual %h", $time,
                   want_row.row_bits, seen_row.row_bits);
        end
        if (seen_row.last_row != want_row.last_row) begin
          mismatch_count++;
          $display("%0t last_row: expected %0b actual %0b", $time,
                   want_row.last_row, seen_row.last_row);
        end
      end
    end
  end

  task automatic push_strobe(input logic [3:0] col, input logic [7:0] pins,
                             input logic [15:0] now_ms);
    strobe_t s;
    s.column = col;
    s.pins = pins;
    s.now_ms = now_ms;
    strobe_queue.push_back(s);
    strobes_queued++;
  endtask

  // sampled away from the rising edge so the driver's updates have settled
  task automatic wait_idle();
    @(negedge clk);
    while (strobe_queue.size() != 0 || in_tvalid || expected_rows.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_debounce(input logic [7:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    debounce_ms_model = value;
  endtask

  // one scan of the matrix, sometimes cut short, sometimes followed by stray requests
  task automatic queue_scan_pass();
    int advance;
    int n_cols;
    int n_stray;
    if ($urandom_range(0, 3) == 0) advance = debounce_ms_model + $urandom_range(0, 2);
    else advance = $urandom_range(0, 3);
    scan_ms = scan_ms + 16'(advance);
    if ($urandom_range(0, 3) != 0) begin
      raw_pins[$urandom_range(0, NUM_COLS - 1)] ^= 8'($urandom_range(1, 255));
    end
    n_cols = ($urandom_range(0, 9) == 0) ? $urandom_range(1, NUM_COLS - 1) : NUM_COLS;
    for (int c = 0; c < n_cols; c++) push_strobe(4'(c), raw_pins[c], scan_ms);
    if ($urandom_range(0, 7) == 0) begin
      n_stray = $urandom_range(1, 3);
      for (int k = 0; k < n_stray; k++) begin
        push_strobe(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    int phase;
    for (int c = 0; c < NUM_COLS; c++) begin
      column_image[c] = '0;
      raw_pins[c] = '0;
    end
    change_pending = 1'b0;
    change_ms = '0;
    debounce_ms_model = 8'd5;
    commit_count = 0;
    mismatch_count = 0;
    strobes_queued = 0;
    steady_run = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // default debounce: boundary, same-request change on the last column, wrap
    push_strobe(4'd15, 8'h00, 16'd0);
    push_strobe(4'd0, 8'hFF, 16'd100);
    push_strobe(4'd15, 8'h00, 16'd105);
    push_strobe(4'd15, 8'h00, 16'd106);
    push_strobe(4'd15, 8'h01, 16'd200);
    push_strobe(4'd15, 8'h01, 16'd300);
    for (int i = 0; i < 8; i++) push_strobe(4'(i + 1), 8'(1 << i), 16'hFFF0);
    push_strobe(4'd15, 8'h01, 16'h0003);
    push_strobe(4'd14, 8'hFF, 16'hFFFF);
    push_strobe(4'd15, 8'h01, 16'h0004);
    push_strobe(4'd15, 8'h01, 16'h0005);
    wait_idle();
    write_debounce(8'd0);
    push_strobe(4'd3, 8'h5A, 16'd1000);
    push_strobe(4'd15, 8'h01, 16'd1000);
    push_strobe(4'd15, 8'h01, 16'd1001);
    wait_idle();
    write_debounce(8'd255);
    push_strobe(4'd7, 8'hC3, 16'd2000);
    push_strobe(4'd15, 8'h01, 16'd2255);
    push_strobe(4'd15, 8'h01, 16'd2256);

    scan_ms = 16'($urandom_range(0, 65535));
    for (int c = 0; c < NUM_COLS; c++) raw_pins[c] = 8'($urandom_range(0, 255));
    phase = 0;
    while (strobes_queued < 156 && phase < 80) begin
      wait_idle();
      if (phase == 0) write_debounce(8'($urandom_range(0, 255)));
      else write_debounce(8'($urandom_range(0, 12)));
      if (strobes_queued >= 100) steady_run = 1'b1;
      repeat (3) queue_scan_pass();
      phase++;
    end
    wait_idle();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
